// File: hw/rtl/decimal_text_value_scaler_defines.svh
// ----------------------------------------------------------------------------
// decimal_text_value_scaler_defines
// Assertion macros for the decimal text value scaler. Define NO_ASSERTIONS
// to compile them out.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_VALUE_SCALER_DEFINES_SVH
`define DECIMAL_TEXT_VALUE_SCALER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on the rising clock, off during reset
`define DTVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define DTVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DTVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define DTVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/dtvs_pkg.sv
// ----------------------------------------------------------------------------
// dtvs_pkg
// Widths, constants and the decimal place table of the text value scaler.
// ----------------------------------------------------------------------------
package dtvs_pkg;

	localparam int VALUE_BITS = 16;
	localparam int PCT_W      = 10;
	localparam int ACC_EXT_W  = VALUE_BITS + 4;
	localparam int PROD_W     = VALUE_BITS + PCT_W;
	// remainder must also hold the clamp threshold (27 bits)
	localparam int REM_W      = (PROD_W > 27) ? PROD_W : 27;
	localparam int PLACE_W    = 3;
	localparam int CNT_W      = 4;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
	localparam logic [PCT_W-1:0]      PCT_RESET = PCT_W'(100);
	localparam logic [PLACE_W-1:0]    MAX_PLACE = PLACE_W'(5);
	localparam logic [CNT_W-1:0]      CNT_TEN   = CNT_W'(10);

	// products at or above 100 * 10^6 give a scaled value past 999999
	localparam logic [REM_W-1:0] CLAMP_LIMIT = REM_W'(100_000_000);
	localparam logic [REM_W-1:0] CLAMP_FILL  = REM_W'(99_999_999);

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	// register word index
	localparam logic REG_SCALE_PERCENT = 1'b0;

	// weight of one decimal place of floor(product / 100), seen in product units
	function automatic logic [REM_W-1:0] place_pow(input logic [PLACE_W-1:0] place);
		logic [REM_W-1:0] w;
		case (place)
			3'd0:    w = REM_W'(100);
			3'd1:    w = REM_W'(1_000);
			3'd2:    w = REM_W'(10_000);
			3'd3:    w = REM_W'(100_000);
			3'd4:    w = REM_W'(1_000_000);
			3'd5:    w = REM_W'(10_000_000);
			default: w = REM_W'(100);
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/decimal_text_value_scaler.sv
// Digit character: accumulated, no output. Closing character or end of text with
// an open run: a multiply state, a clamp state, then one compare-subtract
// per cycle on a shared unit over 6 decimal places, held while the output
// stalls; a copied character then follows from the emit state. Other
// non-digits go through the emit state; end of text alone gives no output.
// Asynchronous active-low reset; scale_percent resets to 100, no clear pass.
// ----------------------------------------------------------------------------
// decimal_text_value_scaler
// Gathers decimal digit runs, scales them by a percentage and re-emits them
// as ASCII digits, passing other characters through.
// ----------------------------------------------------------------------------
`include "decimal_text_value_scaler_defines.svh"

module decimal_text_value_scaler
	import dtvs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// APB-style register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_in,
	input  logic              end_of_text,
	// output channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        char_out,
	output logic              last_of_run
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_CLAMP = 3'd2;
	localparam logic [2:0] ST_DIG   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]            state_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  inside_q;
	logic [PCT_W-1:0]      percent_q;
	logic [REM_W-1:0]      rem_q;
	logic [PLACE_W-1:0]    place_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  started_q;
	logic [7:0]            char_q;
	logic                  end_q;
	logic                  out_valid_q;
	logic [7:0]            char_out_q;
	logic                  last_q;

	logic                  cfg_wr;
	logic                  in_fire;
	logic                  is_digit;
	logic [ACC_EXT_W-1:0]  acc_ext;
	logic [VALUE_BITS-1:0] acc_next;
	logic [PROD_W-1:0]     prod;
	logic [REM_W-1:0]      pow_cur;
	logic                  ge;
	logic                  show_digit;
	logic                  can_load;
	logic                  emit_digit;
	logic                  dig_fire;
	logic                  emit_char;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_SCALE_PERCENT);
	assign prdata = (paddr[2] == REG_SCALE_PERCENT) ? DATA_W'(percent_q) : '0;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign is_digit = !end_of_text && (char_in >= ASCII_ZERO) && (char_in <= ASCII_NINE);

	// acc * 10 + digit, saturating
	assign acc_ext  = ACC_EXT_W'({acc_q, 3'b000}) + ACC_EXT_W'({acc_q, 1'b0})
		+ ACC_EXT_W'(char_in[3:0]);
	assign acc_next = (acc_ext > ACC_EXT_W'(VALUE_MAX)) ? VALUE_MAX : acc_ext[VALUE_BITS-1:0];

	assign prod = PROD_W'(acc_q) * PROD_W'(percent_q);

	// shared compare-subtract unit
	assign pow_cur    = place_pow(place_q);
	assign ge         = (rem_q >= pow_cur);
	assign show_digit = (cnt_q != '0) || started_q || (place_q == '0);
	assign can_load   = !out_valid_q || out_ready;
	assign emit_digit = (state_q == ST_DIG) && !ge && show_digit && can_load;
	assign dig_fire   = (state_q == ST_DIG) && !ge && (!show_digit || can_load);
	assign emit_char  = (state_q == ST_EMIT) && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			inside_q    <= 1'b0;
			percent_q   <= PCT_RESET;
			place_q     <= '0;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				percent_q <= pwdata[PCT_W-1:0];
			end
			if (emit_digit || emit_char) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (is_digit) begin
							acc_q    <= acc_next;
							inside_q <= 1'b1;
						end else if (inside_q) begin
							state_q <= ST_MUL;
						end else if (!end_of_text) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MUL: begin
					acc_q    <= '0;
					inside_q <= 1'b0;
					state_q  <= ST_CLAMP;
				end
				ST_CLAMP: begin
					place_q   <= MAX_PLACE;
					cnt_q     <= '0;
					started_q <= 1'b0;
					state_q   <= ST_DIG;
				end
				ST_DIG: begin
					if (ge) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (dig_fire) begin
						started_q <= started_q | (cnt_q != '0);
						cnt_q     <= '0;
						if (place_q == '0) begin
							state_q <= end_q ? ST_IDLE : ST_EMIT;
						end else begin
							place_q <= place_q - PLACE_W'(1);
						end
					end
				end
				ST_EMIT: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire && !is_digit) begin
			char_q <= char_in;
			end_q  <= end_of_text;
		end
		case (state_q)
			ST_MUL: begin
				rem_q <= REM_W'(prod);
			end
			ST_CLAMP: begin
				if (rem_q >= CLAMP_LIMIT) begin
					rem_q <= CLAMP_FILL;
				end
			end
			ST_DIG: begin
				if (ge) begin
					rem_q <= rem_q - pow_cur;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
		if (emit_digit) begin
			char_out_q <= ASCII_ZERO + 8'(cnt_q);
			last_q     <= (place_q == '0) && end_q;
		end else if (emit_char) begin
			char_out_q <= char_q;
			last_q     <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign char_out    = char_out_q;
	assign last_of_run = last_q;

	`DTVS_ASSERT_NOW(a_digit_range, clk, arst_n, state_q == ST_DIG, cnt_q < CNT_TEN,
		"decimal digit count ran past nine")
	`DTVS_ASSERT_NOW(a_place_range, clk, arst_n, state_q == ST_DIG, place_q <= MAX_PLACE,
		"decimal place out of range")
	`DTVS_ASSERT_NOW(a_acc_clear, clk, arst_n, !inside_q, acc_q == '0,
		"accumulator holds a value with no open run")
	`DTVS_ASSERT_NEXT(a_mul_closes, clk, arst_n, state_q == ST_MUL,
		!inside_q && state_q == ST_CLAMP, "run not closed after multiply")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives text into the decimal text value scaler and checks every character
// it returns. A scoreboard gathers digit runs, scales them by the current
// percentage and queues the expected characters. The configuration is changed
// between phases once the block has gone idle.
// ----------------------------------------------------------------------------
module testbench;
	import dtvs_pkg::*;

	localparam int                SETTLE_CYCLES = 100;
	localparam int                LONG_HOLD     = 300;
	localparam longint unsigned   SCALED_CAP    = 999_999;
	localparam logic [ADDR_W-1:0] PCT_ADDR      = ADDR_W'(4 * int'(REG_SCALE_PERCENT));
	localparam logic [ADDR_W-1:0] SPARE_ADDR    = ADDR_W'(4);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} out_char_t;

	class scaled_text_board;
		logic [VALUE_BITS-1:0] run_value;
		bit                    in_run;
		logic [PCT_W-1:0]      percent;
		out_char_t             expected_q[$];
		int                    mismatches;

		function new();
			run_value  = '0;
			in_run     = 1'b0;
			percent    = PCT_RESET;
			mismatches = 0;
		endfunction

		function void set_percent(logic [PCT_W-1:0] pct);
			percent = pct;
		endfunction

		// one accepted input transaction -> zero or more expected characters
		function void note_char(logic [7:0] c, logic eot);
			longint unsigned grown;
			longint unsigned scaled;
			logic [7:0]      digits[6];
			int              n;
			int              added;
			out_char_t       e;
			if (!eot && c >= ASCII_ZERO && c <= ASCII_NINE) begin
				grown = 64'(run_value) * 10 + 64'(c) - 64'(ASCII_ZERO);
				if (grown > 64'(VALUE_MAX))
					grown = 64'(VALUE_MAX);
				run_value = grown[VALUE_BITS-1:0];
				in_run = 1'b1;
				return;
			end
			added = 0;
			if (in_run) begin
				scaled = 64'(run_value) * 64'(percent) / 100;
				if (scaled > SCALED_CAP)
					scaled = SCALED_CAP;
				n = 0;
				do begin
					digits[n] = ASCII_ZERO + 8'(scaled % 10);
					n++;
					scaled = scaled / 10;
				end while (scaled != 0 && n < 6);
				for (int k = n - 1; k >= 0; k--) begin
					e.ch = digits[k];
					e.last = 1'b0;
					expected_q.push_back(e);
					added++;
				end
			end
			run_value = '0;
			in_run = 1'b0;
			if (!eot) begin
				e.ch = c;
				e.last = 1'b0;
				expected_q.push_back(e);
				added++;
			end
			if (added > 0)
				expected_q[expected_q.size() - 1].last = 1'b1;
		endfunction

		task report(string msg);
			$display("ERROR at %0t ns: %s", $time, msg);
			mismatches++;
		endtask

		task check_char(logic [7:0] c, logic last);
			out_char_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected char 0x%02h last %0b", c, last));
				return;
			end
			e = expected_q.pop_front();
			if (c !== e.ch)
				report($sformatf("char_out 0x%02h, expected 0x%02h", c, e.ch));
			if (last !== e.last)
				report($sformatf("last_of_run %0b, expected %0b (char 0x%02h)",
					last, e.last, e.ch));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid, in_ready;
	logic [7:0]        char_in;
	logic              end_of_text;
	logic              out_valid, out_ready;
	logic [7:0]        char_out;
	logic              last_of_run;

	scaled_text_board board;
	int               items_sent;
	bit               tx_calm, rx_calm, rx_hold_req;
	int               stall_left;

	decimal_text_value_scaler u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_in     (char_in),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_out    (char_out),
		.last_of_run (last_of_run)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#11_000_000;
		$display("Mismatches found");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (c >= ASCII_ZERO && c <= ASCII_NINE);
		return c;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_char(char_out, last_of_run);
			if (in_valid && in_ready)
				board.note_char(char_in, end_of_text);
		end
	end

	// receiver: random stalls, plus one long hold on request
	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				stall_left = LONG_HOLD;
				rx_hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// called at a falling edge; returns at a falling edge
	task send_char(input logic [7:0] c, input logic eot);
		int gap;
		in_valid <= 1'b1;
		char_in <= c;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		@(negedge clk);
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			char_in <= 8'($urandom);
			end_of_text <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	task send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	task drain_results();
		in_valid <= 1'b0;
		while (board.expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (addr == PCT_ADDR)
			board.set_percent(data[PCT_W-1:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// upper bits of the word carry junk; only the low field counts
	task set_scale(input logic [PCT_W-1:0] pct);
		logic [DATA_W-1:0] w;
		w = $urandom;
		w[PCT_W-1:0] = pct;
		drain_results();
		write_reg(PCT_ADDR, w);
	endtask

	task burst_random();
		int r;
		int ndig;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
			for (int k = 0; k < ndig; k++)
				send_char(ASCII_ZERO + 8'($urandom_range(0, 9)), 1'b0);
			if ($urandom_range(0, 4) == 0)
				send_char(8'($urandom), 1'b1);
			else
				send_char(non_digit(), 1'b0);
		end else if (r == 6) begin
			// values at and just past the accumulator limit
			send_text($urandom_range(0, 1) ? "65535" : "65536");
			send_char(non_digit(), 1'b0);
		end else begin
			send_char(8'($urandom), $urandom_range(0, 7) == 0);
		end
	endtask

	task run_phase(input int count);
		int start;
		start = items_sent;
		while (items_sent - start < count)
			burst_random();
	endtask

	initial begin
		board = new();
		items_sent = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		rx_hold_req = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		char_in = '0;
		end_of_text = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed text at the reset scale of 100 percent
		send_text("0,");
		send_text("65535x");
		send_text("99999 ");
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h41, 1'b1);
		send_char(ASCII_ZERO + 8'd7, 1'b0);
		send_char(ASCII_ZERO + 8'd5, 1'b1);
		send_text("007;");
		send_char(ASCII_ZERO - 8'd1, 1'b0);
		send_char(ASCII_NINE + 8'd1, 1'b0);

		// write to an unmapped word must not disturb the scale
		drain_results();
		write_reg(SPARE_ADDR, $urandom);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		run_phase(45);

		set_scale(PCT_W'(1000));
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		run_phase(60);

		set_scale(PCT_W'(0));
		run_phase(55);

		// out-of-range scale, with the output held off to back up the input
		set_scale('1);
		rx_hold_req = 1'b1;
		repeat (40) send_char(non_digit(), 1'b0);
		run_phase(40);

		set_scale(PCT_W'(1));
		tx_calm = 1'b1;
		run_phase(55);

		set_scale(PCT_W'($urandom_range(2, 999)));
		tx_calm = 1'b0;
		rx_calm = 1'b1;
		run_phase(60);

		set_scale(PCT_RESET);
		rx_calm = 1'b0;
		run_phase(60);

		drain_results();
		if (board.mismatches == 0 && board.expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
